[rtl/fpa_pkg.sv]
// shared opcodes, request type and defaults for the q24.8 fixed-point alu
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int FIFO_DEPTH    = 2;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_NE       = 4'd8,
    OP_EQ       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } fpa_op_t;

  // classified request as it sits in the queue
  typedef struct packed {
    fpa_op_t            op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               cmp;
    logic               dz;
  } fpa_item_t;

endpackage

[rtl/fpa_in_if.sv]
// request channel: opcode and two raw operands
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input opcode, input operand_a, input operand_b,
                  output ready);
endinterface

[rtl/fpa_out_if.sv]
// result channel: raw result and flags
interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic               divide_by_zero;
  logic               divide_overflow;

  modport source (output valid, output result_value, output compare_true,
                  output divide_by_zero, output divide_overflow, input ready);
  modport sink   (input valid, input result_value, input compare_true,
                  input divide_by_zero, input divide_overflow, output ready);
endinterface

[rtl/fpa_front.sv]
// front end: decodes a request, resolves comparisons and zero divisor
module fpa_front
  import fpa_pkg::*;
(
  input  logic [3:0]         opcode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output fpa_item_t          item
);

  fpa_op_t op;
  logic    cmp;

  assign op = fpa_op_t'(opcode);

  always_comb begin
    unique case (op)
      OP_GT:   cmp = operand_a >  operand_b;
      OP_LT:   cmp = operand_a <  operand_b;
      OP_GE:   cmp = operand_a >= operand_b;
      OP_LE:   cmp = operand_a <= operand_b;
      OP_NE:   cmp = operand_a != operand_b;
      OP_EQ:   cmp = operand_a == operand_b;
      default: cmp = 1'b0;
    endcase
  end

  assign item.op  = op;
  assign item.a   = operand_a;
  assign item.b   = operand_b;
  assign item.cmp = cmp;
  assign item.dz  = (op == OP_DIV) && (operand_b == 32'sd0);

endmodule

[rtl/fpa_fifo.sv]
// short request queue between front and back
module fpa_fifo
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  fpa_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output fpa_item_t head
);

  localparam int AW = $clog2(FIFO_DEPTH);

  fpa_item_t       mem_r [FIFO_DEPTH];
  logic [AW-1:0]   wr_r, rd_r;
  logic [AW:0]     cnt_r;

  assign full      = (cnt_r == (AW+1)'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(FIFO_DEPTH-1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == AW'(FIFO_DEPTH-1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

[rtl/fpa_back.sv]
// back end: operand stage, bit-per-stage divider line, result register
module fpa_back
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  fpa_item_t  item,
  output logic       item_pop,
  fpa_out_if.source  out_ch
);

  localparam int NW = 32 + FRAC_BITS;  // numerator magnitude width
  localparam int NS = NW;              // one quotient bit per stage

  logic              v_r   [NS+1];
  fpa_op_t           op_r  [NS+1];
  logic [31:0]       res_r [NS+1];
  logic              cmp_r [NS+1];
  logic              dz_r  [NS+1];
  logic              neg_r [NS+1];
  logic [31:0]       rem_r [NS+1];
  logic [NW-1:0]     nq_r  [NS+1];
  logic [31:0]       dvs_r [NS+1];
  logic signed [63:0] prod_r;

  logic [31:0]   rem_nxt [NS];
  logic [NW-1:0] nq_nxt  [NS];
  logic [31:0]   res_nxt [NS];

  logic        en;
  logic [31:0] a_mag, b_mag, res0;

  logic              out_v_r;
  logic [31:0]       out_res_r;
  logic              out_cmp_r, out_dz_r, out_ovf_r;
  logic [NW-1:0]     q;
  logic              ovf;
  logic [31:0]       div_res;

  assign en       = !out_v_r || out_ch.ready;
  assign item_pop = en && item_valid;

  always_comb begin
    a_mag = item.a[31] ? 32'(-item.a) : item.a;
    b_mag = item.b[31] ? 32'(-item.b) : item.b;
    case (item.op)
      OP_ADD:      res0 = item.a + item.b;
      OP_SUB:      res0 = item.a - item.b;
      OP_MIN:      res0 = (item.a < item.b) ? item.a : item.b;
      OP_MAX:      res0 = (item.a > item.b) ? item.a : item.b;
      OP_INC:      res0 = item.a + 32'sd1;
      OP_DEC:      res0 = item.a - 32'sd1;
      OP_FROM_INT: res0 = 32'(item.a <<< FRAC_BITS);
      OP_TO_INT:   res0 = 32'(item.a >>> FRAC_BITS);
      default:     res0 = '0;
    endcase
  end

  // restoring division step, plus multiply product slice after stage 0
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      logic [32:0] rem2;
      logic        ge;
      rem2       = {rem_r[k], nq_r[k][NW-1]};
      ge         = rem2 >= {1'b0, dvs_r[k]};
      rem_nxt[k] = ge ? 32'(rem2 - {1'b0, dvs_r[k]}) : rem2[31:0];
      nq_nxt[k]  = {nq_r[k][NW-2:0], ge};
      res_nxt[k] = (k == 0 && op_r[k] == OP_MUL) ? prod_r[FRAC_BITS+31:FRAC_BITS]
                                                 : res_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= item_valid;
      for (int k = 0; k < NS; k++) v_r[k+1] <= v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0]  <= item.op;
      res_r[0] <= res0;
      cmp_r[0] <= item.cmp;
      dz_r[0]  <= item.dz;
      neg_r[0] <= item.a[31] ^ item.b[31];
      rem_r[0] <= '0;
      nq_r[0]  <= {a_mag, {FRAC_BITS{1'b0}}};
      dvs_r[0] <= b_mag;
      prod_r   <= 64'(item.a) * 64'(item.b);
      for (int k = 0; k < NS; k++) begin
        op_r[k+1]  <= op_r[k];
        res_r[k+1] <= res_nxt[k];
        cmp_r[k+1] <= cmp_r[k];
        dz_r[k+1]  <= dz_r[k];
        neg_r[k+1] <= neg_r[k];
        rem_r[k+1] <= rem_nxt[k];
        nq_r[k+1]  <= nq_nxt[k];
        dvs_r[k+1] <= dvs_r[k];
      end
    end
  end

  // sign and saturate the quotient magnitude
  always_comb begin
    q = nq_r[NS];
    if (!neg_r[NS]) begin
      ovf     = |q[NW-1:31];
      div_res = ovf ? 32'h7fff_ffff : q[31:0];
    end else begin
      ovf     = (|q[NW-1:32]) || (q[31] && (|q[30:0]));
      div_res = ovf ? 32'h8000_0000 : 32'(-q[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cmp_r <= cmp_r[NS];
      if (op_r[NS] == OP_DIV) begin
        out_dz_r  <= dz_r[NS];
        out_ovf_r <= !dz_r[NS] && ovf;
        out_res_r <= dz_r[NS] ? '0 : div_res;
      end else begin
        out_dz_r  <= 1'b0;
        out_ovf_r <= 1'b0;
        out_res_r <= res_r[NS];
      end
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.result_value    = out_res_r;
  assign out_ch.compare_true    = out_cmp_r;
  assign out_ch.divide_by_zero  = out_dz_r;
  assign out_ch.divide_overflow = out_ovf_r;

endmodule

[rtl/fixed_point_alu_q24_8.sv]
// top level of the signed q24.8 fixed-point alu
//
// in_ch carries one request per valid/ready handshake: a 4-bit opcode and two
// raw signed operands. out_ch returns exactly one result per request, in
// request order: result_value plus the compare_true, divide_by_zero and
// divide_overflow flags.
// throughput is one request per cycle for every opcode while out_ch stays ready.
// all opcodes travel the same fixed-length line so results never reorder; its
// length is set by the divider, which resolves one quotient bit per stage over
// FRAC_BITS+32 stages.
// the multiply uses one 32x32 product register ahead of the slice.
// a two-entry queue sits between decode and execution; when out_ch stalls
// the execution line freezes, the queue fills and in_ch.ready drops.
// synchronous active-low reset empties the queue and clears all valid bits;
// no result is offered until a new request arrives.
module fixed_point_alu_q24_8
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic     clk,
  input  logic     rst_n,
  fpa_in_if.sink   in_ch,
  fpa_out_if.source out_ch
);

  fpa_item_t dec_item, head_item;
  logic      full, not_empty, pop;

  assign in_ch.ready = !full;

  fpa_front u_front (
    .opcode    (in_ch.opcode),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .item      (dec_item)
  );

  fpa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_ch.valid && !full),
    .push_item (dec_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head_item)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (not_empty),
    .item       (head_item),
    .item_pop   (pop),
    .out_ch     (out_ch)
  );

endmodule

[test/tb_top.sv]
// testbench for the q24.8 fixed-point alu: directed table, random requests, predictor check
`timescale 1ns / 100ps

module tb_top
  import fpa_pkg::*;
();

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int LATENCY    = FRAC + 34;
  localparam int N_RANDOM   = 1000;
  localparam int N_QUIET    = 150;
  localparam int CYCLE_MAX  = 600000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic               dz;
    logic               ovf;
  } alu_res_t;

  typedef struct packed {
    fpa_op_t            op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               known;
    alu_res_t           res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fpa_in_if  in_if();
  fpa_out_if out_if();

  fixed_point_alu_q24_8 u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  always #5 clk = ~clk;

  alu_res_t pending_q[$];
  int       err_cnt = 0;
  int       req_cnt = 0;
  int       res_cnt = 0;
  int       cycle_cnt = 0;
  int       op_hits[16];
  bit       quiet = 1'b0;
  int       stall_left = 0;

  // bit-exact model of one alu request
  function automatic alu_res_t alu_predict(fpa_op_t op, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_res_t r;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    logic signed [63:0] quo;
    r = '0;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: begin
        prod = 64'(a) * 64'(b);
        r.value = prod[FRAC +: 32];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = 64'(a) <<< FRAC;
          quo = num / 64'(b);
          if (quo > 64'sd2147483647) begin
            r.value = 32'sh7fffffff;
            r.ovf = 1'b1;
          end else if (quo < -64'sd2147483648) begin
            r.value = 32'sh80000000;
            r.ovf = 1'b1;
          end else begin
            r.value = quo[31:0];
          end
        end
      end
      OP_GT: r.cmp = a > b;
      OP_LT: r.cmp = a < b;
      OP_GE: r.cmp = a >= b;
      OP_LE: r.cmp = a <= b;
      OP_NE: r.cmp = a != b;
      OP_EQ: r.cmp = a == b;
      OP_MIN: r.value = (a < b) ? a : b;
      OP_MAX: r.value = (a > b) ? a : b;
      OP_INC: r.value = a + 32'sd1;
      OP_DEC: r.value = a - 32'sd1;
      OP_FROM_INT: r.value = a << FRAC;
      default: r.value = a >>> FRAC;
    endcase
    return r;
  endfunction

  // operands weighted toward small values and edges, still full-range often
  function automatic logic signed [31:0] pick_operand();
    logic signed [31:0] edges[6];
    int sel;
    edges = '{32'sh7fffffff, 32'sh80000000, 32'sd1, -32'sd1, 32'sd256, -32'sd256};
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom;
    if (sel < 7) return $signed($urandom_range(0, 16383)) - 32'sd8192;
    if (sel == 7) return edges[$urandom_range(0, 5)];
    if (sel == 8) return 32'sd0;
    return $signed($urandom_range(0, 2047)) - 32'sd1024 <<< FRAC;
  endfunction

  dir_row_t dir_tab[] = '{
    '{OP_ADD, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 1'b0, 1'b0, 1'b0}},
    '{OP_ADD, 32'sh7fffffff, 32'sd1, 1'b1, '{32'sh80000000, 1'b0, 1'b0, 1'b0}},
    '{OP_SUB, 32'sh80000000, 32'sd1, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0, 1'b0}},
    '{OP_MUL, 32'sd256, 32'sd256, 1'b1, '{32'sd256, 1'b0, 1'b0, 1'b0}},
    '{OP_MUL, 32'sh80000000, 32'sh80000000, 1'b0, '0},
    '{OP_MUL, 32'sh7fffffff, -32'sd1, 1'b0, '0},
    '{OP_DIV, 32'sd256, 32'sd0, 1'b1, '{32'sd0, 1'b0, 1'b1, 1'b0}},
    '{OP_DIV, 32'sh7fffffff, 32'sd1, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0, 1'b1}},
    '{OP_DIV, 32'sh80000000, 32'sd1, 1'b1, '{32'sh80000000, 1'b0, 1'b0, 1'b1}},
    '{OP_DIV, 32'sh80000000, -32'sd1, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0, 1'b1}},
    '{OP_DIV, -32'sd768, 32'sd512, 1'b0, '0},
    '{OP_GT, 32'sh7fffffff, 32'sh80000000, 1'b1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
    '{OP_LT, 32'sh7fffffff, 32'sh80000000, 1'b1, '{32'sd0, 1'b0, 1'b0, 1'b0}},
    '{OP_GE, 32'sd5, 32'sd5, 1'b1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
    '{OP_LE, -32'sd5, 32'sd5, 1'b1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
    '{OP_NE, 32'sd5, 32'sd5, 1'b1, '{32'sd0, 1'b0, 1'b0, 1'b0}},
    '{OP_EQ, 32'sh80000000, 32'sh80000000, 1'b1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
    '{OP_MIN, 32'sh80000000, 32'sh7fffffff, 1'b1, '{32'sh80000000, 1'b0, 1'b0, 1'b0}},
    '{OP_MAX, 32'sh80000000, 32'sh7fffffff, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0, 1'b0}},
    '{OP_MIN, 32'sd7, 32'sd7, 1'b1, '{32'sd7, 1'b0, 1'b0, 1'b0}},
    '{OP_INC, 32'sh7fffffff, 32'sd3, 1'b1, '{32'sh80000000, 1'b0, 1'b0, 1'b0}},
    '{OP_DEC, 32'sh80000000, 32'sd3, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0, 1'b0}},
    '{OP_FROM_INT, 32'sd1, 32'sd0, 1'b1, '{32'sd256, 1'b0, 1'b0, 1'b0}},
    '{OP_FROM_INT, 32'sh00ffffff, 32'sd0, 1'b1, '{32'shffffff00, 1'b0, 1'b0, 1'b0}},
    '{OP_TO_INT, 32'sh80000000, 32'sd0, 1'b1, '{32'shff800000, 1'b0, 1'b0, 1'b0}}
  };

  // drive one request and hold it until taken
  task automatic send_request(fpa_op_t op, logic signed [31:0] a, logic signed [31:0] b,
                              alu_res_t want);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.opcode    <= op;
    in_if.operand_a <= a;
    in_if.operand_b <= b;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    pending_q.push_back(want);
    op_hits[op]++;
    req_cnt++;
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        res_cnt++;
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result value=%h cmp=%b dz=%b ovf=%b", $time,
                   out_if.result_value, out_if.compare_true, out_if.divide_by_zero,
                   out_if.divide_overflow);
          err_cnt++;
        end else begin
          alu_res_t w;
          w = pending_q.pop_front();
          if (out_if.result_value !== w.value || out_if.compare_true !== w.cmp ||
              out_if.divide_by_zero !== w.dz || out_if.divide_overflow !== w.ovf) begin
            $display("%0t: mismatch expected value=%h cmp=%b dz=%b ovf=%b", $time,
                     w.value, w.cmp, w.dz, w.ovf);
            $display("%0t:          actual   value=%h cmp=%b dz=%b ovf=%b", $time,
                     out_if.result_value, out_if.compare_true, out_if.divide_by_zero,
                     out_if.divide_overflow);
            err_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= (stall_left == 1);
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left <= $urandom_range(1, 16);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    fpa_op_t op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    in_if.valid     = 1'b0;
    in_if.opcode    = OP_ADD;
    in_if.operand_a = '0;
    in_if.operand_b = '0;
    foreach (op_hits[i]) op_hits[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_request(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b,
                   dir_tab[i].known ? dir_tab[i].res
                                    : alu_predict(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b));
    end

    // drain fully before the random part
    in_if.valid <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_QUIET) quiet = 1'b1;
      op = fpa_op_t'($urandom_range(0, 15));
      a = pick_operand();
      b = ($urandom_range(0, 3) == 0) ? a : pick_operand();
      send_request(op, a, b, alu_predict(op, a, b));
    end
    in_if.valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);

    $display("%0d requests sent over all 16 opcodes, %0d results checked", req_cnt, res_cnt);
    $display("div requests %0d, mul requests %0d, with random stalls on both sides",
             op_hits[OP_DIV], op_hits[OP_MUL]);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
